[design/plip_pkg.sv]
`timescale 1ns / 1ps

package plip_pkg;

    // item kinds
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_INTERP  = 2'd1;
    localparam logic [1:0] ACT_NEAREST = 2'd2;

    // configuration register indexes
    localparam int         CFG_IW          = 1;
    localparam logic [0:0] REG_NUM_POINTS  = 1'b0;
    localparam logic [0:0] REG_COORD_SCALE = 1'b1;

    // squared distance, 2^-32 units, and the search limit of 1e10
    localparam int              DIST_W     = 67;
    localparam logic [66:0]     DIST_LIMIT = 67'h2540BE40000000000;

    // shared multiplier operands and product
    typedef logic signed [33:0] t_mul_op;
    typedef logic signed [67:0] t_mul_prod;

    // normalize divider widths
    localparam int NUMER_W = 46;
    localparam int DENOM_W = 32;
    typedef logic [NUMER_W-1:0] t_numer;

endpackage

[design/plip_mul.sv]
`timescale 1ns / 1ps

module plip_mul (
    input  logic               i_clk,
    input  plip_pkg::t_mul_op  i_a,
    input  plip_pkg::t_mul_op  i_b,
    output plip_pkg::t_mul_prod o_p
);

    plip_pkg::t_mul_prod r_p;

    // registered signed product
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[design/plip_sqrt.sv]
`timescale 1ns / 1ps

module plip_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    localparam logic [4:0] LAST_STEP = 5'd31;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_s;
    logic [35:0] trial;
    logic        ge;

    // one result bit per cycle, two radicand bits shifted in
    assign rem_s = {r_rem[33:0], r_x[63:62]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = (rem_s >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_x    <= {r_x[61:0], 2'b00};
                r_rem  <= ge ? (rem_s - trial) : rem_s;
                r_root <= {r_root[30:0], ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[design/plip_div.sv]
`timescale 1ns / 1ps

module plip_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  plip_pkg::t_numer                 i_numer,
    input  logic [plip_pkg::DENOM_W-1:0]     i_denom,
    output logic                             o_done,
    output logic [15:0]                      o_quot
);

    localparam int         NW        = plip_pkg::NUMER_W;
    localparam int         DW        = plip_pkg::DENOM_W;
    localparam logic [5:0] LAST_STEP = 6'(NW - 1);

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [NW-1:0] r_n;
    logic [DW-1:0] r_d;
    logic [DW:0]   r_rem;
    logic [DW:0]   rem_s;
    logic          ge;

    // restoring division, one quotient bit per cycle
    assign rem_s = {r_rem[DW-1:0], r_n[NW-1]};
    assign ge    = (rem_s >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_n    <= i_numer;
                r_d    <= i_denom;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_n   <= {r_n[NW-2:0], ge};
                r_rem <= ge ? (rem_s - {1'b0, r_d}) : rem_s;
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_n[15:0];

endmodule

[design/polyline_interp_and_nearest_point.sv]
`timescale 1ns / 1ps

// Path point table with interpolation and nearest entry lookup.
// Input: an item is taken when start is high and busy is low. A load writes
// one table entry in that cycle and gives no result; busy stays low.
// An interpolate item keeps busy high through its last state, the one with
// o_done: one coordinate multiply, two table reads, six blends on the
// shared multiplier, three squares, a 32 step square root and three 46
// step divides for the up vector; a zero length up vector skips them.
// A nearest item scans its entries in turn, then reads the best one; each
// entry is one table read and three squares on the shared multiplier.
// The result is shown for one cycle with o_done high; the receiver cannot
// stall, and busy falls in the cycle after o_done.
// Configuration: write channel i_cfg_valid / o_cfg_ready (always ready),
// i_cfg_index 0 num_points, 1 coord_scale; write only while idle (unchecked).
// Reset: synchronous active low; num_points 2, coord_scale 0. The table
// has no reset and must be loaded before it is read.
module polyline_interp_and_nearest_point #(
    parameter int MAX_POINTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [7:0]                  i_entry_index,
    input  logic signed [31:0]          i_point_x,
    input  logic signed [31:0]          i_point_y,
    input  logic signed [31:0]          i_point_z,
    input  logic signed [15:0]          i_up_x,
    input  logic signed [15:0]          i_up_y,
    input  logic signed [15:0]          i_up_z,
    input  logic [31:0]                 i_path_coord,
    input  logic [7:0]                  i_edge_cutoff,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [plip_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    output logic                        o_done,
    output logic signed [31:0]          o_out_x,
    output logic signed [31:0]          o_out_y,
    output logic signed [31:0]          o_out_z,
    output logic signed [15:0]          o_axis_x,
    output logic signed [15:0]          o_axis_y,
    output logic signed [15:0]          o_axis_z
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (CW > 8) ? CW : 8;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_I_MUL  = 5'd1;
    localparam logic [4:0] S_I_PROD = 5'd2;
    localparam logic [4:0] S_I_RDA  = 5'd3;
    localparam logic [4:0] S_I_RDB  = 5'd4;
    localparam logic [4:0] S_I_RDC  = 5'd5;
    localparam logic [4:0] S_BL0    = 5'd6;
    localparam logic [4:0] S_BL1    = 5'd7;
    localparam logic [4:0] S_BL2    = 5'd8;
    localparam logic [4:0] S_SQ0    = 5'd9;
    localparam logic [4:0] S_SQ1    = 5'd10;
    localparam logic [4:0] S_SQS    = 5'd11;
    localparam logic [4:0] S_SQRT   = 5'd12;
    localparam logic [4:0] S_DV0    = 5'd13;
    localparam logic [4:0] S_DV1    = 5'd14;
    localparam logic [4:0] S_N_CHK  = 5'd15;
    localparam logic [4:0] S_N_W    = 5'd16;
    localparam logic [4:0] S_N_D    = 5'd17;
    localparam logic [4:0] S_N_M    = 5'd18;
    localparam logic [4:0] S_N_A    = 5'd19;
    localparam logic [4:0] S_N_CMP  = 5'd20;
    localparam logic [4:0] S_N_W2   = 5'd21;
    localparam logic [4:0] S_N_R    = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;

    logic [4:0]  r_state;
    logic [8:0]  r_num_points;
    logic [31:0] r_coord_scale;

    // table memories
    logic [95:0] pos_mem [MAX_POINTS];
    logic [47:0] up_mem  [MAX_POINTS];
    logic [95:0] r_rd_pos;
    logic [47:0] r_rd_up;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_end;

    // item and working registers
    logic [31:0]        r_coord;
    logic signed [31:0] r_q     [3];
    logic [7:0]         r_cut;
    logic signed [31:0] r_a_pos [3];
    logic signed [15:0] r_a_up  [3];
    logic signed [31:0] r_b_pos [3];
    logic signed [15:0] r_b_up  [3];
    logic [15:0]        r_t;
    logic [16:0]        r_w0;
    logic [2:0]         r_k;
    logic signed [49:0] r_acc;
    logic signed [32:0] r_v     [3];
    logic [63:0]        r_sq;
    logic [31:0]        r_len;
    logic [IW-1:0]      r_i;
    logic [AW-1:0]      r_best;
    logic [plip_pkg::DIST_W-1:0] r_bd;
    logic [plip_pkg::DIST_W-1:0] r_dacc;
    logic signed [31:0] r_opos  [3];
    logic signed [15:0] r_oaxis [3];

    logic [31:0]   np32;
    logic [31:0]   n_eff32;
    logic [CW-1:0] n_eff;
    logic [CW-1:0] n_last;
    logic [1:0]    kk;
    logic [63:0]   prod;
    logic [23:0]   start_idx;
    logic signed [49:0] bl_sum;
    logic signed [49:0] rnd;
    logic signed [32:0] vabs;
    logic [31:0]   vmag;
    logic signed [32:0] dsig;
    logic [32:0]   dmag;
    logic signed [33:0] part_a;
    logic signed [33:0] part_b;
    logic          load_wr;
    logic          accept;

    plip_pkg::t_mul_op   mul_a;
    plip_pkg::t_mul_op   mul_b;
    plip_pkg::t_mul_prod mul_p;
    logic                sq_start;
    logic                sq_done;
    logic [31:0]         sq_root;
    logic                div_start;
    logic                div_done;
    logic [15:0]         div_quot;
    plip_pkg::t_numer    div_numer;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // entry count in use, clamped to the table
    assign np32    = {23'd0, r_num_points};
    assign n_eff32 = (np32 < 32'd2) ? 32'd2 :
                     ((np32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : np32);
    assign n_eff   = n_eff32[CW-1:0];
    assign n_last  = n_eff - CW'(1);

    // component select: position parts first, then up parts
    assign kk = (r_k >= 3'd3) ? 2'(r_k - 3'd3) : r_k[1:0];

    assign prod      = mul_p[63:0];
    assign start_idx = prod[63:40];
    assign bl_sum    = r_acc + mul_p[49:0];
    assign rnd       = bl_sum + 50'sd32768;

    assign vabs = (r_v[kk] < 0) ? -r_v[kk] : r_v[kk];
    assign vmag = vabs[31:0];
    assign dsig = 33'(r_q[kk]) - 33'(r_a_pos[kk]);
    assign dmag = (dsig < 0) ? 33'(-dsig) : 33'(dsig);

    assign part_a = (r_k < 3'd3) ? 34'(r_a_pos[kk]) : 34'(r_a_up[kk]);
    assign part_b = (r_k < 3'd3) ? 34'(r_b_pos[kk]) : 34'(r_b_up[kk]);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_I_MUL: begin
                mul_a = {2'b00, r_coord};
                mul_b = {2'b00, r_coord_scale};
            end
            S_BL0: begin
                mul_a = part_a;
                mul_b = {17'd0, r_w0};
            end
            S_BL1: begin
                mul_a = part_b;
                mul_b = {18'd0, r_t};
            end
            S_SQ0: begin
                mul_a = {2'b00, vmag};
                mul_b = {2'b00, vmag};
            end
            S_N_M: begin
                mul_a = {1'b0, dmag};
                mul_b = {1'b0, dmag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    plip_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign sq_start = (r_state == S_SQS);

    plip_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign div_start = (r_state == S_DV0) && (r_len != 32'd0);
    assign div_numer = {vmag, 14'd0} + {15'd0, r_len[31:1]};

    plip_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (r_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // table write port and registered read port
    assign load_wr = accept && (i_action == plip_pkg::ACT_LOAD) &&
                     ({24'd0, i_entry_index} < 32'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            pos_mem[AW'(i_entry_index)] <= {i_point_z, i_point_y, i_point_x};
            up_mem[AW'(i_entry_index)]  <= {i_up_z, i_up_y, i_up_x};
        end
        r_rd_pos <= pos_mem[r_addr];
        r_rd_up  <= up_mem[r_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points  <= 9'd2;
            r_coord_scale <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                plip_pkg::REG_NUM_POINTS:  r_num_points  <= i_cfg_data[8:0];
                plip_pkg::REG_COORD_SCALE: r_coord_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_coord <= i_path_coord;
                        r_q[0]  <= i_point_x;
                        r_q[1]  <= i_point_y;
                        r_q[2]  <= i_point_z;
                        r_cut   <= i_edge_cutoff;
                        r_i     <= IW'(i_edge_cutoff);
                        r_best  <= '0;
                        r_bd    <= plip_pkg::DIST_LIMIT;
                        if (i_action == plip_pkg::ACT_INTERP) begin
                            r_state <= S_I_MUL;
                        end else if (i_action == plip_pkg::ACT_NEAREST) begin
                            r_state <= S_N_CHK;
                        end
                    end
                end
                S_I_MUL: begin
                    r_state <= S_I_PROD;
                end
                S_I_PROD: begin
                    // start index and fraction, clamped at the last entry
                    if (start_idx >= 24'(n_last)) begin
                        r_addr <= AW'(n_last);
                        r_end  <= AW'(n_last);
                        r_t    <= '0;
                        r_w0   <= 17'h10000;
                    end else begin
                        r_addr <= AW'(start_idx);
                        r_end  <= AW'(start_idx) + AW'(1);
                        r_t    <= prod[39:24];
                        r_w0   <= 17'h10000 - {1'b0, prod[39:24]};
                    end
                    r_state <= S_I_RDA;
                end
                S_I_RDA: begin
                    r_addr  <= r_end;
                    r_state <= S_I_RDB;
                end
                S_I_RDB: begin
                    r_a_pos[0] <= r_rd_pos[31:0];
                    r_a_pos[1] <= r_rd_pos[63:32];
                    r_a_pos[2] <= r_rd_pos[95:64];
                    r_a_up[0]  <= r_rd_up[15:0];
                    r_a_up[1]  <= r_rd_up[31:16];
                    r_a_up[2]  <= r_rd_up[47:32];
                    r_state    <= S_I_RDC;
                end
                S_I_RDC: begin
                    r_b_pos[0] <= r_rd_pos[31:0];
                    r_b_pos[1] <= r_rd_pos[63:32];
                    r_b_pos[2] <= r_rd_pos[95:64];
                    r_b_up[0]  <= r_rd_up[15:0];
                    r_b_up[1]  <= r_rd_up[31:16];
                    r_b_up[2]  <= r_rd_up[47:32];
                    r_k        <= '0;
                    r_state    <= S_BL0;
                end
                S_BL0: begin
                    r_state <= S_BL1;
                end
                S_BL1: begin
                    r_acc   <= mul_p[49:0];
                    r_state <= S_BL2;
                end
                S_BL2: begin
                    // blend done: round positions, keep up parts exact
                    if (r_k < 3'd3) begin
                        r_opos[kk] <= rnd[47:16];
                    end else begin
                        r_v[kk] <= bl_sum[32:0];
                    end
                    if (r_k == 3'd5) begin
                        r_k     <= '0;
                        r_sq    <= '0;
                        r_state <= S_SQ0;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_BL0;
                    end
                end
                S_SQ0: begin
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_sq <= r_sq + mul_p[63:0];
                    if (r_k == 3'd2) begin
                        r_k     <= '0;
                        r_state <= S_SQS;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_SQ0;
                    end
                end
                S_SQS: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_len   <= sq_root;
                        r_k     <= '0;
                        r_state <= S_DV0;
                    end
                end
                S_DV0: begin
                    // zero length up vector gives a zero axis
                    if (r_len == 32'd0) begin
                        r_oaxis[kk] <= '0;
                        if (r_k == 3'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 3'd1;
                        end
                    end else begin
                        r_state <= S_DV1;
                    end
                end
                S_DV1: begin
                    if (div_done) begin
                        r_oaxis[kk] <= (r_v[kk] < 0) ? -div_quot : div_quot;
                        if (r_k == 3'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_DV0;
                        end
                    end
                end
                S_N_CHK: begin
                    // end of scan range reached: fetch the best entry
                    if (({1'b0, r_i} + (IW + 1)'(r_cut)) >= (IW + 1)'(n_eff)) begin
                        r_addr  <= r_best;
                        r_state <= S_N_W2;
                    end else begin
                        r_addr  <= AW'(r_i);
                        r_state <= S_N_W;
                    end
                end
                S_N_W: begin
                    r_state <= S_N_D;
                end
                S_N_D: begin
                    r_a_pos[0] <= r_rd_pos[31:0];
                    r_a_pos[1] <= r_rd_pos[63:32];
                    r_a_pos[2] <= r_rd_pos[95:64];
                    r_k        <= '0;
                    r_dacc     <= '0;
                    r_state    <= S_N_M;
                end
                S_N_M: begin
                    r_state <= S_N_A;
                end
                S_N_A: begin
                    r_dacc <= r_dacc + {2'b00, mul_p[64:0]};
                    if (r_k == 3'd2) begin
                        r_state <= S_N_CMP;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_N_M;
                    end
                end
                S_N_CMP: begin
                    // strictly smaller wins, so ties keep the lower index
                    if (r_dacc < r_bd) begin
                        r_best <= AW'(r_i);
                        r_bd   <= r_dacc;
                    end
                    r_i     <= r_i + IW'(1);
                    r_state <= S_N_CHK;
                end
                S_N_W2: begin
                    r_state <= S_N_R;
                end
                S_N_R: begin
                    r_opos[0]  <= r_rd_pos[31:0];
                    r_opos[1]  <= r_rd_pos[63:32];
                    r_opos[2]  <= r_rd_pos[95:64];
                    r_oaxis[0] <= '0;
                    r_oaxis[1] <= '0;
                    r_oaxis[2] <= '0;
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_done   = (r_state == S_OUT);
    assign o_out_x  = r_opos[0];
    assign o_out_y  = r_opos[1];
    assign o_out_z  = r_opos[2];
    assign o_axis_x = r_oaxis[0];
    assign o_axis_y = r_oaxis[1];
    assign o_axis_z = r_oaxis[2];

endmodule

[design/plip_chk.sv]
`timescale 1ns / 1ps

module plip_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_action,
    input logic       o_done
);

    // a result only appears while an item is in work
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // the block is idle again right after a result
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy after result strobe");

    // a load finishes in its own cycle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == plip_pkg::ACT_LOAD)) |=> !busy && !o_done)
        else $error("load item left the block busy");

    // a query starts work on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_action == plip_pkg::ACT_INTERP) ||
                            (i_action == plip_pkg::ACT_NEAREST))) |=> busy)
        else $error("query item not taken into work");

endmodule

bind polyline_interp_and_nearest_point plip_chk u_plip_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_action (i_action),
    .o_done   (o_done)
);
